[design/pcpa_pkg.sv]
// package for the per-cpu page allocator: sequencer states, status codes,
// register indexes and fixed field widths; no dependencies
package pcpa_pkg;

    localparam int ADDR_W     = 40;
    localparam int COUNT_W    = 16;
    localparam int PAGE_SHIFT = 12;
    localparam int STATUS_W   = 2;
    localparam int CPU_ID_W   = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOMEM   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADADDR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 1'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE_CHK,
        ST_FREE_WR,
        ST_OWN_RD,
        ST_OWN_DATA,
        ST_SCAN,
        ST_WALK_RD,
        ST_WALK_DATA
    } pcpa_state_t;

endpackage

[design/pcpa_ram.sv]
// generic single-write, single-read synchronous ram with registered read
// depends on nothing
module pcpa_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/per_cpu_page_allocator_with_steal.sv]
// top level of the per-cpu page allocator with stealing
// depends on pcpa_pkg and pcpa_ram (next-link table)
//
// Usage:
//   A request beat is taken when start is high and busy is low: req_type
//   (0 allocate, 1 free), cpu_id and page_address. One result beat follows,
//   shown for one cycle with done high: status and granted_address.
//   Limits are written on wr_en / wr_index / wr_data; the user must do so
//   only while the block is idle, as the block itself does not enforce it.
// Steps, start to done:
//   free: address check, then push
//   allocate from own list: one next-link table read
//   steal: the cpu scan, one count a cycle, then one next-link table read per
//   page taken, through the table's single read port
//   no page anywhere: the full cpu scan, then a no-memory result
// A new request may start in the cycle that done is shown.
// Reset clears the free counts and the limits take their defaults; heads
// and links need no clearing since a count of zero hides them.
// The receiver cannot stall: each result is held for exactly one cycle.
module per_cpu_page_allocator_with_steal #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768,
    parameter int STEAL_MAX = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  req_type,
    input  logic [pcpa_pkg::CPU_ID_W-1:0]          cpu_id,
    input  logic [pcpa_pkg::ADDR_W-1:0]            page_address,
    output logic                                  done,
    output logic [pcpa_pkg::STATUS_W-1:0]          status,
    output logic [pcpa_pkg::ADDR_W-1:0]            granted_address,
    input  logic                                  wr_en,
    input  logic [pcpa_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [pcpa_pkg::ADDR_W-1:0]            wr_data
);

    import pcpa_pkg::*;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SCAN_W = $clog2(NUM_CPUS + 1);
    localparam int TAKE_W = $clog2(STEAL_MAX + 1);
    localparam int IDXF_W = ADDR_W - PAGE_SHIFT;
    localparam int NUM_IDS = 1 << CPU_ID_W;

    pcpa_state_t state_reg, state_next;

    logic [ADDR_W-1:0]  low_limit_reg, high_limit_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [CPU_W-1:0]   cpu_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  diff_reg;
    logic               bad_reg;
    logic [PAGE_W-1:0]  head_reg, cur_reg, req_head_reg;
    logic [CPU_W-1:0]   victim_reg;
    logic [TAKE_W-1:0]  take_reg, steps_reg;
    logic               first_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]  granted_reg;

    logic [PAGE_W-1:0]  list_head_reg [NUM_CPUS];
    logic [COUNT_W-1:0] free_count_reg [NUM_CPUS];

    logic [CPU_W-1:0]   cpu_mod [NUM_IDS];

    logic               ram_we;
    logic [PAGE_W-1:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    // cpu id modulo cpu count, as a constant table
    for (genvar g = 0; g < NUM_IDS; g++)
    begin : g_cpu_mod
        assign cpu_mod[g] = CPU_W'(g % NUM_CPUS);
    end

    // scan and free-check helpers
    logic [CPU_W-1:0]   scan_idx;
    logic               scan_end, scan_hit;
    logic [COUNT_W-1:0] scan_cnt;
    logic [TAKE_W-1:0]  scan_take;
    logic               free_ok;
    logic [PAGE_W-1:0]  free_idx;
    logic [ADDR_W-1:0]  grant_addr;

    assign scan_idx  = scan_reg[CPU_W-1:0];
    assign scan_end  = (scan_reg == SCAN_W'(NUM_CPUS));
    assign scan_cnt  = scan_end ? '0 : free_count_reg[scan_idx];
    assign scan_hit  = !scan_end && (scan_idx != cpu_reg) && (scan_cnt != '0);
    assign scan_take = (scan_cnt > COUNT_W'(STEAL_MAX)) ? TAKE_W'(STEAL_MAX)
                                                        : scan_cnt[TAKE_W-1:0];
    assign free_ok   = !bad_reg && (diff_reg[ADDR_W-1:PAGE_SHIFT] < IDXF_W'(NUM_PAGES));
    assign free_idx  = diff_reg[PAGE_W+PAGE_SHIFT-1:PAGE_SHIFT];
    assign grant_addr = base_reg + {{(IDXF_W-PAGE_W){1'b0}}, head_reg, {PAGE_SHIFT{1'b0}}};

    // next-link table
    pcpa_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = req_type ? ST_FREE_CHK : ST_OWN_RD;
                end
            end
            ST_FREE_CHK:  state_next = ST_FREE_WR;
            ST_FREE_WR:   state_next = ST_IDLE;
            ST_OWN_RD:
            begin
                state_next = (free_count_reg[cpu_reg] != '0) ? ST_OWN_DATA : ST_SCAN;
            end
            ST_OWN_DATA:  state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_hit)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:   state_next = ST_WALK_DATA;
            ST_WALK_DATA:
            begin
                state_next = (steps_reg == TAKE_W'(1)) ? ST_IDLE : ST_WALK_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // table port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = list_head_reg[cpu_reg];
        ram_raddr = cur_reg;
        case (state_reg)
            ST_FREE_WR:  ram_we    = free_ok;
            ST_OWN_RD:   ram_raddr = list_head_reg[cpu_reg];
            default:     ram_raddr = cur_reg;
        endcase
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            low_limit_reg  <= 40'd2147483648;
            high_limit_reg <= 40'd2281701376;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                free_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (wr_en)
            begin
                case (wr_index)
                    CFG_LOW_LIMIT:  low_limit_reg  <= wr_data;
                    CFG_HIGH_LIMIT: high_limit_reg <= wr_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_FREE_WR:
                begin
                    done_reg <= 1'b1;
                    if (free_ok && free_count_reg[cpu_reg] != COUNT_MAX)
                    begin
                        free_count_reg[cpu_reg] <= free_count_reg[cpu_reg] + 1'b1;
                    end
                end
                ST_OWN_DATA:
                begin
                    done_reg <= 1'b1;
                    free_count_reg[cpu_reg] <= free_count_reg[cpu_reg] - 1'b1;
                end
                ST_SCAN:
                begin
                    done_reg <= scan_end;
                end
                ST_WALK_DATA:
                begin
                    if (steps_reg == TAKE_W'(1))
                    begin
                        done_reg <= 1'b1;
                        free_count_reg[victim_reg] <= free_count_reg[victim_reg]
                                                      - COUNT_W'(take_reg);
                        if (take_reg > TAKE_W'(1))
                        begin
                            free_count_reg[cpu_reg] <= COUNT_W'(take_reg - 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        base_reg <= (low_limit_reg + ADDR_W'(4095)) & ~ADDR_W'(4095);
        case (state_reg)
            ST_IDLE:
            begin
                cpu_reg  <= cpu_mod[cpu_id];
                addr_reg <= page_address;
                scan_reg <= '0;
            end
            ST_FREE_CHK:
            begin
                bad_reg  <= (addr_reg[PAGE_SHIFT-1:0] != '0) || (addr_reg < low_limit_reg)
                            || (addr_reg >= high_limit_reg);
                diff_reg <= addr_reg - low_limit_reg;
            end
            ST_FREE_WR:
            begin
                status_reg  <= free_ok ? STAT_OK : STAT_BADADDR;
                granted_reg <= '0;
                if (free_ok)
                begin
                    list_head_reg[cpu_reg] <= free_idx;
                end
            end
            ST_OWN_RD:
            begin
                head_reg <= list_head_reg[cpu_reg];
            end
            ST_OWN_DATA:
            begin
                list_head_reg[cpu_reg] <= ram_rdata;
                status_reg  <= STAT_OK;
                granted_reg <= grant_addr;
            end
            ST_SCAN:
            begin
                scan_reg <= scan_reg + 1'b1;
                if (scan_end)
                begin
                    status_reg  <= STAT_NOMEM;
                    granted_reg <= '0;
                end
                else if (scan_hit)
                begin
                    head_reg   <= list_head_reg[scan_idx];
                    cur_reg    <= list_head_reg[scan_idx];
                    victim_reg <= scan_idx;
                    take_reg   <= scan_take;
                    steps_reg  <= scan_take;
                    first_reg  <= 1'b1;
                end
            end
            ST_WALK_DATA:
            begin
                first_reg <= 1'b0;
                steps_reg <= steps_reg - 1'b1;
                cur_reg   <= ram_rdata;
                if (first_reg)
                begin
                    req_head_reg <= ram_rdata;
                end
                if (steps_reg == TAKE_W'(1))
                begin
                    list_head_reg[victim_reg] <= ram_rdata;
                    if (take_reg > TAKE_W'(1))
                    begin
                        list_head_reg[cpu_reg] <= req_head_reg;
                    end
                    status_reg  <= STAT_OK;
                    granted_reg <= grant_addr;
                end
            end
            default: ;
        endcase
    end

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (granted_address == '0))
        else $error("error result carries an address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STAT_OK || status == STAT_NOMEM || status == STAT_BADADDR))
        else $error("unknown status code");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the per-cpu page allocator with stealing
// holds a predictor and scoreboard class, directed and random request beats
// depends on pcpa_pkg and per_cpu_page_allocator_with_steal
`timescale 1ns / 100ps

module tb_top;

    import pcpa_pkg::*;

    localparam int TB_CPUS      = 8;
    localparam int TB_PAGES     = 32768;
    localparam int TB_STEAL     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYC   = 24;
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_FREE   = 1'b1;
    localparam logic [ADDR_W-1:0] ADDR_ALL = 40'hFF_FFFF_FFFF;

    // predictor of the allocator and store of owed result beats
    class alloc_scoreboard;
        typedef struct {
            logic [STATUS_W-1:0] st;
            logic [ADDR_W-1:0]   addr;
        } grant_t;

        logic [ADDR_W-1:0]  low_lim;
        logic [ADDR_W-1:0]  high_lim;
        logic [14:0]        link_tab [TB_PAGES];
        logic [14:0]        head_of [TB_CPUS];
        logic [COUNT_W-1:0] count_of [TB_CPUS];
        grant_t             owed [$];
        int                 errors;

        function new();
            low_lim  = 40'd2147483648;
            high_lim = 40'd2281701376;
            foreach (link_tab[i]) link_tab[i] = '0;
            foreach (head_of[i]) head_of[i] = '0;
            foreach (count_of[i]) count_of[i] = '0;
            errors = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
            if (idx == CFG_LOW_LIMIT)
                low_lim = val;
            else
                high_lim = val;
        endfunction

        // base rounded up to a page, address wraps at the field width
        function logic [ADDR_W-1:0] addr_of(logic [14:0] idx);
            logic [ADDR_W:0] base;
            base = ({1'b0, low_lim} + 41'hFFF) & ~41'hFFF;
            return base[ADDR_W-1:0] + {13'd0, idx, 12'd0};
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_request(logic rt, logic [2:0] cpu, logic [ADDR_W-1:0] a);
            grant_t g;
            logic [ADDR_W-1:0] off;
            logic [14:0] hd;
            logic [14:0] tl;
            int take;
            bit found;
            g.st = STAT_OK;
            g.addr = '0;
            if (rt == REQ_FREE)
            begin
                off = a - low_lim;
                if (a[11:0] != 0 || a < low_lim || a >= high_lim || (off >> 12) >= TB_PAGES)
                    g.st = STAT_BADADDR;
                else
                begin
                    link_tab[off[26:12]] = head_of[cpu];
                    head_of[cpu] = off[26:12];
                    if (count_of[cpu] != COUNT_MAX)
                        count_of[cpu]++;
                end
            end
            else if (count_of[cpu] != 0)
            begin
                hd = head_of[cpu];
                head_of[cpu] = link_tab[hd];
                count_of[cpu]--;
                g.addr = addr_of(hd);
            end
            else
            begin
                found = 0;
                // scan other cpus in index order, first with pages is robbed
                for (int v = 0; v < TB_CPUS; v++)
                begin
                    if (!found && v != cpu && count_of[v] != 0)
                    begin
                        found = 1;
                        take = (count_of[v] > TB_STEAL) ? TB_STEAL : count_of[v];
                        hd = head_of[v];
                        tl = hd;
                        for (int j = 1; j < take; j++)
                            tl = link_tab[tl];
                        head_of[v] = link_tab[tl];
                        count_of[v] = count_of[v] - COUNT_W'(take);
                        if (take > 1)
                        begin
                            head_of[cpu] = link_tab[hd];
                            count_of[cpu] = COUNT_W'(take - 1);
                        end
                        g.addr = addr_of(hd);
                    end
                end
                if (!found)
                    g.st = STAT_NOMEM;
            end
            owed.push_back(g);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] a);
            grant_t g;
            if (owed.size() == 0)
            begin
                $error("unexpected result beat: status %0d address %h", st, a);
                errors++;
                return;
            end
            g = owed.pop_front();
            if (st !== g.st)
            begin
                $error("status: expected %0d actual %0d", g.st, st);
                errors++;
            end
            if (a !== g.addr)
            begin
                $error("granted_address: expected %h actual %h", g.addr, a);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 req_type;
    logic [CPU_ID_W-1:0]  cpu_id;
    logic [ADDR_W-1:0]    page_address;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    granted_address;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [ADDR_W-1:0]    wr_data;

    alloc_scoreboard sb;
    int burst_left;
    int cycles;

    per_cpu_page_allocator_with_steal #(
        .NUM_CPUS  (TB_CPUS),
        .NUM_PAGES (TB_PAGES),
        .STEAL_MAX (TB_STEAL)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .cpu_id          (cpu_id),
        .page_address    (page_address),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result beats checked as they show
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, granted_address);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request beat, sent in bursts with random gaps
    task automatic send(logic rt, logic [2:0] cpu, logic [ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_type = rt;
        cpu_id = cpu;
        page_address = a;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_request(rt, cpu, a);
        @(negedge clk);
        start = 1'b0;
    endtask

    // hold off until every owed beat is in, then let the block settle
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        drain();
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
        sb.set_limit(idx, val);
    endtask

    function automatic logic [ADDR_W-1:0] page_at(int idx);
        return sb.addr_of(15'(idx));
    endfunction

    // random traffic: mostly well-formed frees to a few cpus and allocs
    task automatic random_traffic(int n, int max_idx);
        int pick;
        int idx;
        logic [ADDR_W-1:0] a;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_idx)
                                              : $urandom_range(0, (max_idx < 63) ? max_idx : 63);
            if (pick < 50)
                send(REQ_FREE, 3'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                              : $urandom_range(0, 2)),
                     page_at(idx));
            else if (pick < 90)
                send(REQ_ALLOC, 3'($urandom_range(0, 7)), ADDR_W'({$urandom, $urandom}));
            else if (pick < 95)
            begin
                // broken frees: misaligned or just outside the window
                a = page_at(idx) | ADDR_W'($urandom_range(1, 4095));
                if ($urandom_range(0, 1) == 0)
                    a = ($urandom_range(0, 1) == 0) ? sb.high_lim : sb.low_lim - 40'h1000;
                send(REQ_FREE, 3'($urandom_range(0, 7)), a);
            end
            else
                send(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     ADDR_W'({$urandom, $urandom}));
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_ALLOC;
        cpu_id = '0;
        page_address = '0;
        wr_en = 1'b0;
        wr_index = CFG_LOW_LIMIT;
        wr_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: default window, extremes, steals, double free, no memory
        send(REQ_ALLOC, 3'd0, '0);
        send(REQ_FREE, 3'd0, 40'h80_0000_0000 >> 8);
        send(REQ_FREE, 3'd7, 40'h00_87FF_F000);
        send(REQ_FREE, 3'd1, 40'h00_8000_0001);
        send(REQ_FREE, 3'd1, 40'h00_7FFF_F000);
        send(REQ_FREE, 3'd1, 40'h00_8800_0000);
        send(REQ_FREE, 3'd1, '0);
        send(REQ_FREE, 3'd1, ADDR_ALL);
        send(REQ_ALLOC, 3'd0, ADDR_ALL);
        send(REQ_ALLOC, 3'd0, '0);
        for (int i = 1; i <= 5; i++)
            send(REQ_FREE, 3'd2, page_at(i * 3));
        send(REQ_ALLOC, 3'd5, '0);
        send(REQ_ALLOC, 3'd5, '0);
        send(REQ_FREE, 3'd1, page_at(100));
        send(REQ_FREE, 3'd1, page_at(100));
        for (int i = 0; i < 6; i++)
            send(REQ_ALLOC, 3'd4, '0);
        drain();

        random_traffic(400, TB_PAGES - 1);

        // unaligned low limit, high limit past the table
        write_limit(CFG_LOW_LIMIT, 40'h00_8000_0800);
        write_limit(CFG_HIGH_LIMIT, 40'h00_8000_0800 + (40'd40000 << 12));
        send(REQ_FREE, 3'd6, 40'h00_8000_1000 + (40'd32767 << 12));
        send(REQ_FREE, 3'd6, 40'h00_8000_1000 + (40'd32768 << 12));
        random_traffic(350, TB_PAGES - 1);

        // widest window
        write_limit(CFG_LOW_LIMIT, '0);
        write_limit(CFG_HIGH_LIMIT, ADDR_ALL);
        random_traffic(350, TB_PAGES - 1);

        // window at the top of the address space, few pages
        write_limit(CFG_LOW_LIMIT, 40'hFF_FFF8_0000);
        random_traffic(200, 127);

        // empty window: every free refused, allocs drain what is left
        write_limit(CFG_LOW_LIMIT, ADDR_ALL);
        write_limit(CFG_HIGH_LIMIT, '0);
        random_traffic(100, 63);

        drain();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[per_cpu_page_allocator_with_steal.f]
design/pcpa_pkg.sv
design/pcpa_ram.sv
design/per_cpu_page_allocator_with_steal.sv
tb/tb_top.sv
